// ----- src/vsar_pkg.sv -----
// Shared codes and masks for the video scroll and address register set.
// Used by the top level; depends on nothing.
package vsar_pkg;

  localparam int OAM_DEPTH = 256;
  localparam int OAM_AW    = $clog2(OAM_DEPTH);

  typedef enum logic [3:0] {
    KIND_CPU_WR     = 4'd0,
    KIND_CPU_RD     = 4'd1,
    KIND_INC_X      = 4'd2,
    KIND_INC_Y      = 4'd3,
    KIND_COPY_H     = 4'd4,
    KIND_COPY_V     = 4'd5,
    KIND_VBLANK     = 4'd6,
    KIND_OVERFLOW   = 4'd7,
    KIND_SPR0_HIT   = 4'd8,
    KIND_PRE_CLEAR  = 4'd9
  } kind_t;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_CTRL   = 3'd0;
  localparam reg_idx_t REG_MASK   = 3'd1;
  localparam reg_idx_t REG_STATUS = 3'd2;
  localparam reg_idx_t REG_OAMADR = 3'd3;
  localparam reg_idx_t REG_OAMDAT = 3'd4;
  localparam reg_idx_t REG_SCROLL = 3'd5;
  localparam reg_idx_t REG_ADDR   = 3'd6;
  localparam reg_idx_t REG_DATA   = 3'd7;

  // Status flag positions.
  localparam int ST_OVERFLOW = 0;
  localparam int ST_SPR0_HIT = 1;
  localparam int ST_VBLANK   = 2;

  // Scroll address fields: fine Y [14:12], name table [11:10],
  // coarse Y [9:5], coarse X [4:0].
  localparam logic [14:0] HORIZ_MASK = 15'h041F;
  localparam logic [14:0] VERT_MASK  = 15'h7BE0;

endpackage

// ----- src/vsar_in_if.sv -----
// Input request channel: valid/ready handshake with one event as payload.
// No dependencies.
interface vsar_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] kind;
  logic [2:0] reg_index;
  logic [7:0] data_in;

  modport source (output valid, kind, reg_index, data_in, input ready);
  modport sink   (input valid, kind, reg_index, data_in, output ready);
endinterface

// ----- src/vsar_out_if.sv -----
// Result channel: valid/ready handshake with one result per event.
// No dependencies.
interface vsar_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [13:0] vram_addr;
  logic        vram_strobe;
  logic        vram_is_write;
  logic [7:0]  vram_wdata;
  logic [14:0] current_addr;
  logic [2:0]  fine_x_out;
  logic        nmi_pulse;
  logic [7:0]  control_out;
  logic [7:0]  mask_out;

  modport source (output valid, read_data, vram_addr, vram_strobe, vram_is_write,
                  vram_wdata, current_addr, fine_x_out, nmi_pulse, control_out,
                  mask_out, input ready);
  modport sink   (input valid, read_data, vram_addr, vram_strobe, vram_is_write,
                  vram_wdata, current_addr, fine_x_out, nmi_pulse, control_out,
                  mask_out, output ready);
endinterface

// ----- src/video_scroll_address_registers.sv -----
// Top level of the picture unit's CPU register set with scroll address logic.
// Depends on vsar_pkg, vsar_in_if and vsar_out_if.
//
//  channel   | dir | handshake           | payload
//  ----------+-----+---------------------+-----------------------------------
//  in_chan   | in  | valid/ready         | kind, reg_index, data_in
//  out_chan  | out | valid/ready         | read_data, vram_*, current_addr, ...
//
// One request per cycle while the result register is not stalled: each request
// goes from the input register through the register update logic into the result register.
// The sprite table is a 256-byte memory with one registered read port that
// always holds the byte at the sprite address; per-entry valid bits make it
// read as zero after reset, so no clearing pass is needed.
// A stalled result holds in the result register; the input register still
// takes a request whenever the request ahead of it moves on.
module video_scroll_address_registers (
  input  logic              clk,
  input  logic              rst_n,
  vsar_in_if.sink           in_chan,
  vsar_out_if.source        out_chan
);
  import vsar_pkg::*;

  // Input register.
  logic              ivld_r;
  logic [3:0]        kind_r;
  reg_idx_t          idx_r;
  logic [7:0]        din_r;

  // Block state.
  logic [14:0]       cur_r, cur_nxt;
  logic [14:0]       tmp_r, tmp_nxt;
  logic [2:0]        fx_r, fx_nxt;
  logic              wt_r, wt_nxt;
  logic [7:0]        ctrl_r, ctrl_nxt;
  logic [7:0]        mask_r, mask_nxt;
  logic [2:0]        stat_r, stat_nxt;
  logic [OAM_AW-1:0] oaddr_r, oaddr_nxt;

  // Sprite table.
  logic [7:0]           oam_mem [OAM_DEPTH];
  logic [OAM_DEPTH-1:0] oam_vld_r;
  logic [7:0]           oam_raw_r;
  logic                 oam_hit_r;
  logic                 oam_we;
  logic [7:0]           oam_q;

  // Result register.
  logic        ovld_r;
  logic [7:0]  rdata_r, rdata_nxt;
  logic [13:0] vaddr_r, vaddr_nxt;
  logic        strobe_r, strobe_nxt;
  logic        iswr_r, iswr_nxt;
  logic [7:0]  wdata_r, wdata_nxt;
  logic        nmi_r, nmi_nxt;

  logic        fire;
  logic        rendering;
  logic [4:0]  coarse_y;
  logic [14:0] port_step;

  assign fire          = ivld_r && (!ovld_r || out_chan.ready);
  assign in_chan.ready = !ivld_r || fire;
  assign rendering     = mask_r[3] || mask_r[4];
  assign oam_q         = oam_hit_r ? oam_raw_r : 8'd0;
  assign port_step     = ctrl_r[2] ? 15'd32 : 15'd1;
  assign coarse_y      = cur_r[9:5];

  always_comb begin
    cur_nxt    = cur_r;
    tmp_nxt    = tmp_r;
    fx_nxt     = fx_r;
    wt_nxt     = wt_r;
    ctrl_nxt   = ctrl_r;
    mask_nxt   = mask_r;
    stat_nxt   = stat_r;
    oaddr_nxt  = oaddr_r;
    oam_we     = 1'b0;
    rdata_nxt  = 8'd0;
    vaddr_nxt  = 14'd0;
    strobe_nxt = 1'b0;
    iswr_nxt   = 1'b0;
    wdata_nxt  = 8'd0;
    nmi_nxt    = 1'b0;
    if (fire) begin
      case (kind_t'(kind_r))
        KIND_CPU_WR: begin
          case (idx_r)
            REG_CTRL: begin
              ctrl_nxt        = din_r;
              tmp_nxt[11:10]  = din_r[1:0];
            end
            REG_MASK:   mask_nxt = din_r;
            REG_OAMADR: oaddr_nxt = din_r[OAM_AW-1:0];
            REG_OAMDAT: begin
              oam_we    = 1'b1;
              oaddr_nxt = oaddr_r + 1'b1;
            end
            REG_SCROLL: begin
              if (!wt_r) begin
                tmp_nxt[4:0] = din_r[7:3];
                fx_nxt       = din_r[2:0];
                wt_nxt       = 1'b1;
              end else begin
                tmp_nxt[14:12] = din_r[2:0];
                tmp_nxt[9:5]   = din_r[7:3];
                wt_nxt         = 1'b0;
              end
            end
            REG_ADDR: begin
              if (!wt_r) begin
                tmp_nxt[14]   = 1'b0;
                tmp_nxt[13:8] = din_r[5:0];
                wt_nxt        = 1'b1;
              end else begin
                tmp_nxt[7:0] = din_r;
                cur_nxt      = {tmp_r[14:8], din_r};
                wt_nxt       = 1'b0;
              end
            end
            REG_DATA: begin
              vaddr_nxt  = cur_r[13:0];
              strobe_nxt = 1'b1;
              iswr_nxt   = 1'b1;
              wdata_nxt  = din_r;
              cur_nxt    = cur_r + port_step;
            end
            default: ;
          endcase
        end
        KIND_CPU_RD: begin
          case (idx_r)
            REG_STATUS: begin
              rdata_nxt           = {stat_r, 5'd0};
              wt_nxt              = 1'b0;
              stat_nxt[ST_VBLANK] = 1'b0;
            end
            REG_OAMDAT: rdata_nxt = oam_q;
            REG_DATA: begin
              vaddr_nxt  = cur_r[13:0];
              strobe_nxt = 1'b1;
              cur_nxt    = cur_r + port_step;
            end
            default: ;
          endcase
        end
        KIND_INC_X: begin
          if (rendering) begin
            if (cur_r[4:0] == 5'd31) begin
              cur_nxt[4:0] = 5'd0;
              cur_nxt[10]  = !cur_r[10];
            end else begin
              cur_nxt[4:0] = cur_r[4:0] + 5'd1;
            end
          end
        end
        KIND_INC_Y: begin
          if (rendering) begin
            if (cur_r[14:12] != 3'd7) begin
              cur_nxt[14:12] = cur_r[14:12] + 3'd1;
            end else begin
              cur_nxt[14:12] = 3'd0;
              // Row 29 is the last visible row and flips the vertical name
              // table; rows 30 and 31 sit in attribute space, and row 31 wraps silently.
              if (coarse_y == 5'd29) begin
                cur_nxt[9:5] = 5'd0;
                cur_nxt[11]  = !cur_r[11];
              end else if (coarse_y == 5'd31) begin
                cur_nxt[9:5] = 5'd0;
              end else begin
                cur_nxt[9:5] = coarse_y + 5'd1;
              end
            end
          end
        end
        KIND_COPY_H: begin
          if (rendering) cur_nxt = (cur_r & VERT_MASK) | (tmp_r & HORIZ_MASK);
        end
        KIND_COPY_V: begin
          if (rendering) cur_nxt = (cur_r & HORIZ_MASK) | (tmp_r & VERT_MASK);
        end
        KIND_VBLANK: begin
          stat_nxt[ST_VBLANK] = 1'b1;
          nmi_nxt             = ctrl_r[7];
        end
        KIND_OVERFLOW:  stat_nxt[ST_OVERFLOW] = 1'b1;
        KIND_SPR0_HIT:  stat_nxt[ST_SPR0_HIT] = 1'b1;
        KIND_PRE_CLEAR: stat_nxt = 3'd0;
        default: ;
      endcase
    end
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ivld_r    <= 1'b0;
      ovld_r    <= 1'b0;
      cur_r     <= '0;
      tmp_r     <= '0;
      fx_r      <= '0;
      wt_r      <= 1'b0;
      ctrl_r    <= '0;
      mask_r    <= '0;
      stat_r    <= '0;
      oaddr_r   <= '0;
      oam_vld_r <= '0;
      oam_hit_r <= 1'b0;
    end else begin
      if (in_chan.ready) ivld_r <= in_chan.valid;
      ovld_r    <= fire || (ovld_r && !out_chan.ready);
      cur_r     <= cur_nxt;
      tmp_r     <= tmp_nxt;
      fx_r      <= fx_nxt;
      wt_r      <= wt_nxt;
      ctrl_r    <= ctrl_nxt;
      mask_r    <= mask_nxt;
      stat_r    <= stat_nxt;
      oaddr_r   <= oaddr_nxt;
      if (oam_we) oam_vld_r[oaddr_r] <= 1'b1;
      // A table write never lands on the next read address, so the old
      // valid bit is the right one.
      oam_hit_r <= oam_vld_r[oaddr_nxt];
    end
  end

  // Input payload register.
  always_ff @(posedge clk) begin
    if (in_chan.ready) begin
      kind_r <= in_chan.kind;
      idx_r  <= in_chan.reg_index;
      din_r  <= in_chan.data_in;
    end
  end

  // Sprite table: one write port and a registered read at the next address.
  always_ff @(posedge clk) begin
    if (oam_we) oam_mem[oaddr_r] <= din_r;
    oam_raw_r <= oam_mem[oaddr_nxt];
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (fire) begin
      rdata_r  <= rdata_nxt;
      vaddr_r  <= vaddr_nxt;
      strobe_r <= strobe_nxt;
      iswr_r   <= iswr_nxt;
      wdata_r  <= wdata_nxt;
      nmi_r    <= nmi_nxt;
    end
  end

  // Scroll, control and mask outputs show the state after the request, which
  // stays put until the next request fires, and that one waits for this result.
  assign out_chan.valid         = ovld_r;
  assign out_chan.read_data     = rdata_r;
  assign out_chan.vram_addr     = vaddr_r;
  assign out_chan.vram_strobe   = strobe_r;
  assign out_chan.vram_is_write = iswr_r;
  assign out_chan.vram_wdata    = wdata_r;
  assign out_chan.current_addr  = cur_r;
  assign out_chan.fine_x_out    = fx_r;
  assign out_chan.nmi_pulse     = nmi_r;
  assign out_chan.control_out   = ctrl_r;
  assign out_chan.mask_out      = mask_r;

  a_oam_step: assert property (@(posedge clk) disable iff (!rst_n)
    oam_we |=> oaddr_r == $past(oaddr_r) + 1'b1)
    else $error("sprite address did not step after a table write");

  a_vblank_set: assert property (@(posedge clk) disable iff (!rst_n)
    fire && kind_r == KIND_VBLANK |=> stat_r[ST_VBLANK])
    else $error("vblank flag not set");

  a_nmi_cause: assert property (@(posedge clk) disable iff (!rst_n)
    fire && nmi_nxt |=> stat_r[ST_VBLANK] && ctrl_r[7] && out_chan.nmi_pulse)
    else $error("nmi pulse without vblank and enable");

  a_status_read: assert property (@(posedge clk) disable iff (!rst_n)
    fire && kind_r == KIND_CPU_RD && idx_r == REG_STATUS |=> !wt_r && !stat_r[ST_VBLANK])
    else $error("status read did not clear toggle and vblank");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !ovld_r |-> in_chan.ready)
    else $error("input stalled with an empty result register");

endmodule
